[src/tccw_pkg.sv]
// Shared types, codes and constants of the text console character writer.
`default_nettype none
package tccw_pkg;

	// Field widths
	localparam int ACTION_W     = 2;
	localparam int CHAR_W       = 8;
	localparam int CELL_INDEX_W = 11;
	localparam int CELL_W       = 16;
	localparam int CURSOR_POS_W = 11;
	localparam int COLOR_W      = 8;
	localparam int ROW_W        = 5;
	localparam int COL_W        = 7;

	// Stream bus widths
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = ACTION_W;
	localparam int M_TDATA_W = 32;

	// Screen geometry defaults
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;
	localparam int TAB_STEP    = 4;

	// Character codes and cell values
	localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'h20;
	localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'h0A;
	localparam logic [CHAR_W-1:0]  CH_RETURN   = 8'h0D;
	localparam logic [CHAR_W-1:0]  CH_TAB      = 8'h09;
	localparam logic [CELL_W-1:0]  RESET_CELL  = 16'h0F20;
	localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h0F;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUT   = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NOP   = 2'd3
	} act_t;

	// Controller to datapath
	typedef struct packed {
		logic take;       // latch the input transfer
		logic exec;       // apply put / read / clear setup
		logic fill;       // write one cell of a fill sweep
		logic init_fill;  // fill with the reset cell value
		logic prime;      // first read of a scroll sweep
		logic scroll;     // one copy step of a scroll sweep
		logic load_out;   // load the result register
	} tccw_cmd_t;

	// Datapath to controller
	typedef struct packed {
		act_t action;
		logic scroll_needed;
		logic sweep_last;
	} tccw_stat_t;

endpackage
`default_nettype wire

[src/tccw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

[src/tccw_ctrl.sv]
// Controller state machine: sequences accept, execute, sweeps and result.
`default_nettype none
module tccw_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	input  wire tccw_pkg::tccw_stat_t stat,
	output tccw_pkg::tccw_cmd_t      cmd
);
	import tccw_pkg::*;

	typedef enum logic [6:0] {
		ST_INIT   = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_EXEC   = 7'b0000100,
		ST_PRIME  = 7'b0001000,
		ST_SCROLL = 7'b0010000,
		ST_CLEAR  = 7'b0100000,
		ST_RESULT = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_INIT: begin
				cmd.fill      = 1'b1;
				cmd.init_fill = 1'b1;
				if (stat.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.take = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.action == ACT_CLEAR) begin
					state_d = ST_CLEAR;
				end else if (stat.action == ACT_PUT && stat.scroll_needed) begin
					state_d = ST_PRIME;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_PRIME: begin
				cmd.prime = 1'b1;
				state_d   = ST_SCROLL;
			end
			ST_SCROLL: begin
				cmd.scroll = 1'b1;
				if (stat.sweep_last) state_d = ST_RESULT;
			end
			ST_CLEAR: begin
				cmd.fill = 1'b1;
				if (stat.sweep_last) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

[src/tccw_dp.sv]
// Datapath: item registers, cursor, colour register, screen RAM and result.
`default_nettype none
module tccw_dp #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [tccw_pkg::ACTION_W-1:0]      action,
	input  wire logic [tccw_pkg::CHAR_W-1:0]        char_code,
	input  wire logic [tccw_pkg::CELL_INDEX_W-1:0]  cell_index,
	input  wire logic                               cfg_we,
	input  wire logic [tccw_pkg::COLOR_W-1:0]       cfg_wdata,
	input  wire tccw_pkg::tccw_cmd_t                cmd,
	output tccw_pkg::tccw_stat_t                    stat,
	output logic      [tccw_pkg::CELL_W-1:0]        cell_data,
	output logic      [tccw_pkg::CURSOR_POS_W-1:0]  cursor_position
);
	import tccw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);

	act_t                    action_q;
	logic [CHAR_W-1:0]       char_q;
	logic [CELL_INDEX_W-1:0] index_q;
	logic [COLOR_W-1:0]      color_q;
	logic [ROW_W-1:0]        row_q;
	logic [COL_W-1:0]        col_q;
	logic [AW-1:0]           sweep_q;
	logic                    read_hit_q;

	logic                    is_lf, is_cr, is_tab, is_print;
	logic [COL_W:0]          col_adv;
	logic                    wrap, at_bottom, read_in_range;
	logic [15:0]             pos;
	logic [CELL_W-1:0]       blank_cell;
	logic                    copy_row;

	logic                    ram_we, ram_re;
	logic [AW-1:0]           ram_waddr, ram_raddr;
	logic [CELL_W-1:0]       ram_wdata, ram_rdata;
	logic [AW:0]             next_src;

	// Cursor decode
	assign is_lf     = (char_q == CH_NEWLINE);
	assign is_cr     = (char_q == CH_RETURN);
	assign is_tab    = (char_q == CH_TAB);
	assign is_print  = !is_lf && !is_cr && !is_tab;
	assign col_adv   = {1'b0, col_q} + (is_tab ? (COL_W+1)'(TAB_STEP) : (COL_W+1)'(1));
	assign wrap      = is_lf || (!is_cr && (col_adv >= (COL_W+1)'(COLUMNS)));
	assign at_bottom = (row_q == ROW_W'(ROWS - 1));
	assign pos       = 16'(row_q) * 16'(COLUMNS) + 16'(col_q);
	assign read_in_range = (32'(index_q) < 32'(CELLS));
	assign blank_cell    = {color_q, CH_SPACE};
	assign copy_row      = (sweep_q < AW'(CELLS - COLUMNS));
	assign next_src      = (AW+1)'(sweep_q) + (AW+1)'(COLUMNS + 1);

	assign stat.action        = action_q;
	assign stat.scroll_needed = wrap && at_bottom;
	assign stat.sweep_last    = (sweep_q == AW'(CELLS - 1));

	// RAM write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sweep_q;
		ram_wdata = blank_cell;
		if (cmd.exec && action_q == ACT_PUT && is_print) begin
			ram_we    = 1'b1;
			ram_waddr = pos[AW-1:0];
			ram_wdata = {color_q, char_q};
		end else if (cmd.fill) begin
			ram_we    = 1'b1;
			ram_wdata = cmd.init_fill ? RESET_CELL : blank_cell;
		end else if (cmd.scroll) begin
			ram_we    = 1'b1;
			ram_wdata = copy_row ? ram_rdata : blank_cell;
		end
	end

	// RAM read port
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = next_src[AW-1:0];
		if (cmd.exec) begin
			ram_re    = (action_q == ACT_READ) && read_in_range;
			ram_raddr = AW'(index_q);
		end else if (cmd.prime) begin
			ram_re    = 1'b1;
			ram_raddr = AW'(COLUMNS);
		end else if (cmd.scroll) begin
			ram_re    = (sweep_q < AW'(CELLS - COLUMNS - 1));
		end
	end

	tccw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Item registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			action_q <= act_t'(action);
			char_q   <= char_code;
			index_q  <= cell_index;
		end
	end

	// Colour, cursor, sweep counter, read flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q    <= RESET_COLOR;
			row_q      <= '0;
			col_q      <= '0;
			sweep_q    <= '0;
			read_hit_q <= 1'b0;
		end else begin
			if (cfg_we) color_q <= cfg_wdata;
			if (cmd.exec) begin
				sweep_q    <= '0;
				read_hit_q <= (action_q == ACT_READ) && read_in_range;
				if (action_q == ACT_CLEAR) begin
					row_q <= '0;
					col_q <= '0;
				end else if (action_q == ACT_PUT) begin
					if (wrap) begin
						col_q <= '0;
						if (!at_bottom) row_q <= row_q + ROW_W'(1);
					end else if (is_cr) begin
						col_q <= '0;
					end else begin
						col_q <= col_adv[COL_W-1:0];
					end
				end
			end else if (cmd.prime) begin
				sweep_q <= '0;
			end else if (cmd.fill || cmd.scroll) begin
				sweep_q <= sweep_q + AW'(1);
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			cell_data       <= read_hit_q ? ram_rdata : '0;
			cursor_position <= pos[CURSOR_POS_W-1:0];
		end
	end
endmodule
`default_nettype wire

[src/text_console_char_writer_top.sv]
// Top level of the text console character writer.
//
// Input stream (s_axis): one transfer per item; tuser carries the action (put
// char, read cell, clear screen, no-op), tdata the character and cell index.
// Output stream (m_axis): one transfer per item with the cell data (reads
// only, else zero) and the linear cursor position after the item.
// Configuration: cfg_we/cfg_wdata write the attribute byte for new cells;
// write it only while the block is idle.
// Flow: an item is taken when s_axis_tready is high; its result goes through
// the execute and result states to m_axis for put, read and no-op items. A put
// leaving the bottom row adds a priming read and a scroll sweep, one RAM write
// per cell; a clear adds a sweep blanking every cell. One item is worked on at
// a time, so s_axis_tready drops from the accept until the result is loaded.
// Reset: all ROWS*COLUMNS cells (2000 at the defaults) are swept to 0x0F20
// with s_axis_tready low; cursor goes home, colour to 0x0F.
// Stall: the result register holds its transfer while m_axis_tready is low;
// the next item may be accepted meanwhile, and its result waits behind it.
`default_nettype none
module text_console_char_writer_top #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [7:0] char_code, [18:8] cell_index, rest zero
	input  wire logic [tccw_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// [1:0] action
	input  wire logic [tccw_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// [15:0] cell_data, [26:16] cursor_position, rest zero
	output logic      [tccw_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input  wire logic                            cfg_we,
	input  wire logic [tccw_pkg::COLOR_W-1:0]    cfg_wdata
);
	import tccw_pkg::*;

	tccw_cmd_t               cmd;
	tccw_stat_t              stat;
	logic [CELL_W-1:0]       cell_data;
	logic [CURSOR_POS_W-1:0] cursor_position;

	tccw_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.stat         (stat),
		.cmd          (cmd)
	);

	tccw_dp #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.action         (s_axis_tuser[ACTION_W-1:0]),
		.char_code      (s_axis_tdata[CHAR_W-1:0]),
		.cell_index     (s_axis_tdata[CHAR_W +: CELL_INDEX_W]),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.cmd            (cmd),
		.stat           (stat),
		.cell_data      (cell_data),
		.cursor_position(cursor_position)
	);

	// Pack result fields
	assign m_axis_tdata = {
		(M_TDATA_W - CELL_W - CURSOR_POS_W)'(0), cursor_position, cell_data};
endmodule
`default_nettype wire

[src/tccw_checker.sv]
// Port-level checker of the text console character writer, bound to the top.
`default_nettype none
module tccw_checker #(
	parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tvalid,
	input wire logic                            s_axis_tready,
	input wire logic [tccw_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [tccw_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
	import tccw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;

	// Stalled result keeps valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result valid dropped while stalled");

	// Stalled result keeps its data
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result data changed while stalled");

	// One item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after a transfer");

	// Cursor position stays on the screen
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (CELLS > 2048) || (32'(m_axis_tdata[26:16]) < 32'(CELLS)))
		else $error("cursor position off screen");

	// A clear still holds off input once its sweep has begun
	a_clear_home: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_CLEAR) && !m_axis_tvalid
		|=> ##1 !s_axis_tready)
		else $error("clear finished without a sweep");
endmodule

bind text_console_char_writer_top tccw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_checker (.*);
`default_nettype wire
